// ===== hdl/gri_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gri_pkg: shared types and constants for the gyro rate integrator
// Field widths, register indexes, the config bundle seen by each axis, and a
// magnitude helper for the rest and limit tests.
// -----------------------------------------------------------------------------
package gri_pkg;

   localparam int AXES     = 3;
   localparam int SAMPLE_W = 16;  // raw sample field width
   localparam int OFFSET_W = 16;
   localparam int BAND_W   = 16;
   localparam int LIMIT_W  = 23;
   localparam int ANGLE_W  = 24;
   localparam int RATE_W   = 17;
   // angle + rate + previous rate, wide enough for the limit test
   localparam int SUM_W    = 26;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = LIMIT_W;

   localparam int REQ_DATA_W = 48;   // 3 x 16 sample bits
   localparam int RSP_DATA_W = 128;  // 3 x 24 angle + 3 x 17 rate, padded

   // register reset values
   localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST   = 16'sd145;
   localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST   = 16'sd0;
   localparam logic signed [OFFSET_W-1:0] OFFSET_Z_RST   = 16'sd60;
   localparam logic [BAND_W-1:0]          REST_BAND_RST  = 16'd57;
   localparam logic [LIMIT_W-1:0]         TURN_LIMIT_RST = 23'd4114286;  // 360 deg

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_X   = 3'd0,
      CSR_OFFSET_Y   = 3'd1,
      CSR_OFFSET_Z   = 3'd2,
      CSR_REST_BAND  = 3'd3,
      CSR_TURN_LIMIT = 3'd4
   } gri_csr_type;

   // settings common to all axes
   typedef struct packed {
      logic [BAND_W-1:0]  rest_band;
      logic [LIMIT_W-1:0] turn_limit;
   } gri_cfg_type;

   // magnitude of a signed value; the most negative code never occurs here
   function automatic logic [SUM_W-1:0] abs_val(input logic signed [SUM_W-1:0] v);
      return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
   endfunction

endpackage

// ===== hdl/gri_axis.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gri_axis: one axis of the rate integrator
// Offset correction, rest-band zeroing and trapezoidal angle accumulation with
// reset at the turn limit. Holds the previous rate and the angle; both update
// when enable is high.
// -----------------------------------------------------------------------------
module gri_axis #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic [gri_pkg::SAMPLE_W-1:0]          sample,
   input  logic signed [gri_pkg::OFFSET_W-1:0]   offset,
   input  gri_pkg::gri_cfg_type                  cfg,
   output logic signed [gri_pkg::ANGLE_W-1:0]    angle_in,
   output logic signed [gri_pkg::RATE_W-1:0]     rate_in
);
   import gri_pkg::*;

   logic signed [ANGLE_W-1:0]     angle_ff;
   logic signed [RATE_W-1:0]      prev_ff;
   logic signed [SAMPLE_BITS-1:0] sample_trim;
   logic signed [RATE_W-1:0]      raw_rate;
   logic                          at_rest;
   logic signed [SUM_W-1:0]       sum;
   logic                          over_limit;

   // only the low SAMPLE_BITS bits carry the sample
   assign sample_trim = sample[SAMPLE_BITS-1:0];
   assign raw_rate    = RATE_W'(sample_trim) - RATE_W'(offset);

   // zero the rate when both it and the kept previous rate are within the band
   assign at_rest = (abs_val(SUM_W'(raw_rate)) <= SUM_W'(cfg.rest_band)) &&
                    (abs_val(SUM_W'(prev_ff))  <= SUM_W'(cfg.rest_band));
   assign rate_in = at_rest ? '0 : raw_rate;

   // trapezoid step, angle clears once it reaches the limit
   assign sum        = SUM_W'(angle_ff) + SUM_W'(rate_in) + SUM_W'(prev_ff);
   assign over_limit = abs_val(sum) >= SUM_W'(cfg.turn_limit);
   assign angle_in   = over_limit ? '0 : sum[ANGLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         prev_ff  <= '0;
      end else if (enable) begin
         angle_ff <= angle_in;
         prev_ff  <= rate_in;
      end
   end

endmodule

// ===== hdl/gyro_rate_integrator.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gyro_rate_integrator: three-axis gyro rate integrator
// Offset-corrects raw gyro samples, zeroes rates inside the rest band and
// integrates roll, pitch and yaw trapezoidally in 0.0000875 degree units.
// -----------------------------------------------------------------------------
// One sample triple per clock is accepted and one result per clock is
// delivered while rsp_tready is high. The req transfer loads the input
// register, and the result register loads from it once it is free; the
// result register drives rsp_tvalid. The rate is set by the per-axis
// accumulate loop, where the angle and previous-rate registers feed back
// through combinational logic. A result waiting on rsp_tready does not
// block the input register from filling. Register writes must be made while
// no sample is in flight; csr_ready is always high.
// -----------------------------------------------------------------------------
module gyro_rate_integrator #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gri_pkg::REQ_DATA_W-1:0]       req_tdata,   // sample_x, sample_y, sample_z
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // roll, pitch, yaw, rate_x, rate_y, rate_z, zero pad
   output logic [gri_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gri_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gri_pkg::CSR_DATA_W-1:0]       csr_data
);
   import gri_pkg::*;

   // configuration registers
   logic signed [OFFSET_W-1:0] offset_ff [AXES];
   logic [BAND_W-1:0]          rest_band_ff;
   logic [LIMIT_W-1:0]         turn_limit_ff;
   gri_cfg_type                cfg;

   // input register
   logic                       s1_valid_ff;
   logic [REQ_DATA_W-1:0]      s1_data_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;

   logic                       rsp_free;
   logic                       advance;
   logic signed [ANGLE_W-1:0]  angle_in [AXES];
   logic signed [RATE_W-1:0]   rate_in  [AXES];
   logic [RSP_DATA_W-1:0]      rsp_data_in;

   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[0]  <= OFFSET_X_RST;
         offset_ff[1]  <= OFFSET_Y_RST;
         offset_ff[2]  <= OFFSET_Z_RST;
         rest_band_ff  <= REST_BAND_RST;
         turn_limit_ff <= TURN_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET_X:   offset_ff[0]  <= csr_data[OFFSET_W-1:0];
            CSR_OFFSET_Y:   offset_ff[1]  <= csr_data[OFFSET_W-1:0];
            CSR_OFFSET_Z:   offset_ff[2]  <= csr_data[OFFSET_W-1:0];
            CSR_REST_BAND:  rest_band_ff  <= csr_data[BAND_W-1:0];
            CSR_TURN_LIMIT: turn_limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.rest_band  = rest_band_ff;
   assign cfg.turn_limit = turn_limit_ff;

   // handshake: input register moves on when the result register can take it
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
      end
   end

   // per-axis datapath and state
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      gri_axis #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_axis (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .sample   (s1_data_ff[a*SAMPLE_W +: SAMPLE_W]),
         .offset   (offset_ff[a]),
         .cfg      (cfg),
         .angle_in (angle_in[a]),
         .rate_in  (rate_in[a])
      );
   end

   assign rsp_data_in = {5'b0, rate_in[2], rate_in[1], rate_in[0],
                         angle_in[2], angle_in[1], angle_in[0]};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
